### rtl/mtd_pkg.sv
// ----------------------------------------------------------------------------
// mtd_pkg
// Types, stage indices and constants shared by the matrix-to-TRS pipeline.
// ----------------------------------------------------------------------------
package mtd_pkg;

    // Pipeline depths of the shared arithmetic units
    localparam int SQRT_LAT = 32;           // one root bit per stage
    localparam int DIV_LAT  = 33;           // setup stage plus one quotient bit per stage

    // Stage indices, counted from the input capture stage
    localparam int ST_SUM   = 1;
    localparam int ST_LEN   = ST_SUM + SQRT_LAT;
    localparam int ST_SIDE0 = ST_LEN + 1;
    localparam int ST_R     = ST_LEN + DIV_LAT + 1;
    localparam int ST_D     = ST_R + 1;
    localparam int ST_S     = ST_D + SQRT_LAT;
    localparam int ST_QS    = ST_S + 1;
    localparam int ST_Q     = ST_S + DIV_LAT;
    localparam int ST_OUT   = ST_Q + 1;

    localparam logic [31:0] Q30_ONE   = 32'h4000_0000;
    localparam logic [30:0] SCALE_MAX = 31'h7fff_ffff;

    typedef logic [1:0] t_branch;
    localparam t_branch BR_W = 2'd0;        // trace positive
    localparam t_branch BR_X = 2'd1;        // x diagonal dominant
    localparam t_branch BR_Y = 2'd2;        // y diagonal dominant
    localparam t_branch BR_Z = 2'd3;        // z diagonal dominant

    typedef struct packed {
        logic signed [31:0] col0_x;
        logic signed [31:0] col0_y;
        logic signed [31:0] col0_z;
        logic signed [31:0] col1_x;
        logic signed [31:0] col1_y;
        logic signed [31:0] col1_z;
        logic signed [31:0] col2_x;
        logic signed [31:0] col2_y;
        logic signed [31:0] col2_z;
        logic signed [31:0] move_x;
        logic signed [31:0] move_y;
        logic signed [31:0] move_z;
    } t_in;

    typedef struct packed {
        logic signed [31:0] out_move_x;
        logic signed [31:0] out_move_y;
        logic signed [31:0] out_move_z;
        logic [30:0]        scale_x;
        logic [30:0]        scale_y;
        logic [30:0]        scale_z;
        logic signed [31:0] quat_x;
        logic signed [31:0] quat_y;
        logic signed [31:0] quat_z;
        logic signed [31:0] quat_w;
        logic               rotation_valid;
    } t_out;

    // Matrix carried alongside the length roots
    typedef struct packed {
        logic [8:0][31:0] elem;
        logic [2:0][31:0] move;
    } t_mat;

    // Sideband carried alongside the normalization and quaternion units
    typedef struct packed {
        logic [2:0][31:0] move;
        logic [2:0][30:0] scale;
        logic             zero;
        t_branch          branch;
        logic [2:0][33:0] num;
        logic [31:0]      qs;
    } t_side;

endpackage

### rtl/mtd_in_if.sv
// ----------------------------------------------------------------------------
// mtd_in_if
// Valid/ready channel carrying one input matrix item.
// ----------------------------------------------------------------------------
interface mtd_in_if ();
    logic          valid;
    logic          ready;
    mtd_pkg::t_in  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/mtd_out_if.sv
// ----------------------------------------------------------------------------
// mtd_out_if
// Valid/ready channel carrying one TRS result item.
// ----------------------------------------------------------------------------
interface mtd_out_if ();
    logic          valid;
    logic          ready;
    mtd_pkg::t_out data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/mtd_sqrt.sv
// ----------------------------------------------------------------------------
// mtd_sqrt
// Pipelined floor square root of a 64-bit value, one root bit per stage.
// ----------------------------------------------------------------------------
module mtd_sqrt (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_x,
    output logic [31:0] o_root
);

    logic [63:0] r_x    [0:mtd_pkg::SQRT_LAT-2];
    logic [33:0] r_rem  [0:mtd_pkg::SQRT_LAT-1];
    logic [31:0] r_root [0:mtd_pkg::SQRT_LAT-1];
    logic [63:0] n_x    [0:mtd_pkg::SQRT_LAT-1];
    logic [33:0] n_rem  [0:mtd_pkg::SQRT_LAT-1];
    logic [31:0] n_root [0:mtd_pkg::SQRT_LAT-1];

    always_comb begin
        logic [63:0] v_x;
        logic [33:0] v_rem;
        logic [31:0] v_root;
        logic [35:0] v_sh;
        logic [35:0] v_tr;
        for (int k = 0; k < mtd_pkg::SQRT_LAT; k++) begin
            if (k == 0) begin
                v_x    = i_x;
                v_rem  = '0;
                v_root = '0;
            end else begin
                v_x    = r_x[k-1];
                v_rem  = r_rem[k-1];
                v_root = r_root[k-1];
            end
            v_sh = {v_rem, v_x[63-2*k -: 2]};
            v_tr = {2'b00, v_root, 2'b01};
            n_x[k] = v_x;
            if (v_sh >= v_tr) begin
                n_rem[k]  = 34'(v_sh - v_tr);
                n_root[k] = {v_root[30:0], 1'b1};
            end else begin
                n_rem[k]  = v_sh[33:0];
                n_root[k] = {v_root[30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < mtd_pkg::SQRT_LAT; k++) begin
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
            end
            for (int k = 0; k < mtd_pkg::SQRT_LAT - 1; k++) begin
                r_x[k] <= n_x[k];
            end
        end
    end

    assign o_root = r_root[mtd_pkg::SQRT_LAT-1];

endmodule

### rtl/mtd_div.sv
// ----------------------------------------------------------------------------
// mtd_div
// Pipelined signed Q2.30 quotient num/den, truncated toward zero and
// saturated to [-1.0, 1.0]; zero when den is zero.
// ----------------------------------------------------------------------------
module mtd_div (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [33:0] i_num,
    input  logic        [33:0] i_den,
    output logic signed [31:0] o_q
);

    localparam int NB = mtd_pkg::DIV_LAT - 1;

    logic [33:0] w_mag;
    logic [61:0] r_p_rem;
    logic [33:0] r_p_den;
    logic        r_p_neg;
    logic        r_p_ovf;
    logic        r_p_zero;

    logic [61:0] r_rem  [0:NB-1];
    logic [31:0] r_q    [0:NB-1];
    logic [33:0] r_den  [0:NB-1];
    logic        r_neg  [0:NB-1];
    logic        r_ovf  [0:NB-1];
    logic        r_zero [0:NB-1];
    logic [61:0] n_rem  [0:NB-1];
    logic [31:0] n_q    [0:NB-1];

    assign w_mag = i_num[33] ? 34'(-i_num) : i_num;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p_rem  <= {w_mag[31:0], 30'd0};
            r_p_den  <= i_den;
            r_p_neg  <= i_num[33];
            r_p_ovf  <= {4'd0, w_mag[31:0]} >= {i_den, 2'b00};
            r_p_zero <= (i_den == '0);
        end
    end

    always_comb begin
        logic [61:0] v_rem;
        logic [31:0] v_q;
        logic [33:0] v_den;
        logic [65:0] v_sh;
        for (int k = 0; k < NB; k++) begin
            if (k == 0) begin
                v_rem = r_p_rem;
                v_q   = '0;
                v_den = r_p_den;
            end else begin
                v_rem = r_rem[k-1];
                v_q   = r_q[k-1];
                v_den = r_den[k-1];
            end
            v_sh = {32'd0, v_den} << (NB - 1 - k);
            n_q[k] = v_q;
            if ({4'd0, v_rem} >= v_sh) begin
                n_rem[k] = 62'({4'd0, v_rem} - v_sh);
                n_q[k][NB-1-k] = 1'b1;
            end else begin
                n_rem[k] = v_rem;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < NB; k++) begin
                r_rem[k] <= n_rem[k];
                r_q[k]   <= n_q[k];
                if (k == 0) begin
                    r_den[k]  <= r_p_den;
                    r_neg[k]  <= r_p_neg;
                    r_ovf[k]  <= r_p_ovf;
                    r_zero[k] <= r_p_zero;
                end else begin
                    r_den[k]  <= r_den[k-1];
                    r_neg[k]  <= r_neg[k-1];
                    r_ovf[k]  <= r_ovf[k-1];
                    r_zero[k] <= r_zero[k-1];
                end
            end
        end
    end

    // Saturate and apply the sign after the last quotient bit
    logic [31:0] w_mq;
    always_comb begin
        if (r_zero[NB-1]) begin
            w_mq = '0;
        end else if (r_ovf[NB-1] || (r_q[NB-1] > mtd_pkg::Q30_ONE)) begin
            w_mq = mtd_pkg::Q30_ONE;
        end else begin
            w_mq = r_q[NB-1];
        end
    end

    assign o_q = r_neg[NB-1] ? -$signed(w_mq) : $signed(w_mq);

endmodule

### rtl/matrix_to_trs_decompose.sv
// ----------------------------------------------------------------------------
// matrix_to_trs_decompose
// Affine matrix to translation, per-axis scale and rotation quaternion.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle while the output does not stall; the pipeline
// holds up to 135 items.
// The depth is set by two 32-stage root units and two 33-stage dividers.
// A stall at the output freezes every stage; nothing is dropped or repeated.
// Reset clears all valid bits; the datapath registers are not reset.
// ----------------------------------------------------------------------------
module matrix_to_trs_decompose (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mtd_in_if.sink     i_in,
    mtd_out_if.source  o_out
);

    localparam int ST_OUT = mtd_pkg::ST_OUT;

    // Global advance: move when the output slot is empty or being taken
    logic w_en;
    logic r_vld [0:ST_OUT];

    assign w_en       = !r_vld[ST_OUT] || o_out.ready;
    assign i_in.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= ST_OUT; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_vld[0] <= i_in.valid;
            for (int k = 1; k <= ST_OUT; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: capture the matrix, square each element magnitude
    // ------------------------------------------------------------------
    mtd_pkg::t_mat w_mat;
    logic [31:0]   w_mag [0:8];
    logic [63:0]   r_sq  [0:8];
    mtd_pkg::t_mat r_mat [0:mtd_pkg::ST_LEN];

    assign w_mat.elem[0] = i_in.data.col0_x;
    assign w_mat.elem[1] = i_in.data.col0_y;
    assign w_mat.elem[2] = i_in.data.col0_z;
    assign w_mat.elem[3] = i_in.data.col1_x;
    assign w_mat.elem[4] = i_in.data.col1_y;
    assign w_mat.elem[5] = i_in.data.col1_z;
    assign w_mat.elem[6] = i_in.data.col2_x;
    assign w_mat.elem[7] = i_in.data.col2_y;
    assign w_mat.elem[8] = i_in.data.col2_z;
    assign w_mat.move[0] = i_in.data.move_x;
    assign w_mat.move[1] = i_in.data.move_y;
    assign w_mat.move[2] = i_in.data.move_z;

    always_comb begin
        for (int j = 0; j < 9; j++) begin
            w_mag[j] = w_mat.elem[j][31] ? (32'd0 - w_mat.elem[j]) : w_mat.elem[j];
        end
    end

    // Stage 1: sum of squares per column
    logic [63:0] r_sum [0:2];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int j = 0; j < 9; j++) begin
                r_sq[j] <= 64'(w_mag[j]) * 64'(w_mag[j]);
            end
            for (int c = 0; c < 3; c++) begin
                r_sum[c] <= r_sq[3*c] + r_sq[3*c+1] + r_sq[3*c+2];
            end
            r_mat[0] <= w_mat;
            for (int k = 1; k <= mtd_pkg::ST_LEN; k++) begin
                r_mat[k] <= r_mat[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Column lengths, then normalize every basis element by its column
    // ------------------------------------------------------------------
    logic [31:0]        w_len [0:2];
    logic signed [31:0] w_r1  [0:8];

    for (genvar c = 0; c < 3; c++) begin : g_len
        mtd_sqrt u_len (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_x    (r_sum[c]),
            .o_root (w_len[c])
        );
    end

    for (genvar j = 0; j < 9; j++) begin : g_norm
        mtd_div u_norm (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_num (34'($signed(r_mat[mtd_pkg::ST_LEN].elem[j]))),
            .i_den ({2'b00, w_len[j/3]}),
            .o_q   (w_r1[j])
        );
    end

    // ------------------------------------------------------------------
    // Rotation matrix register, then branch select and root argument
    // ------------------------------------------------------------------
    logic signed [31:0] r_r [0:8];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int j = 0; j < 9; j++) begin
                r_r[j] <= w_r1[j];
            end
        end
    end

    // r_r index is column * 3 + row
    logic signed [34:0]   w_r00, w_r11, w_r22, w_tr, w_arg;
    logic signed [33:0]   w_r01, w_r10, w_r02, w_r20, w_r12, w_r21;
    mtd_pkg::t_branch     w_branch;
    logic [2:0][33:0]     w_num;
    logic [63:0]          r_darg;

    assign w_r00 = 35'(r_r[0]);
    assign w_r11 = 35'(r_r[4]);
    assign w_r22 = 35'(r_r[8]);
    assign w_r10 = 34'(r_r[1]);
    assign w_r20 = 34'(r_r[2]);
    assign w_r01 = 34'(r_r[3]);
    assign w_r21 = 34'(r_r[5]);
    assign w_r02 = 34'(r_r[6]);
    assign w_r12 = 34'(r_r[7]);
    assign w_tr  = w_r00 + w_r11 + w_r22;

    always_comb begin
        if (w_tr > 0) begin
            w_branch = mtd_pkg::BR_W;
            w_arg    = w_tr + 35'(mtd_pkg::Q30_ONE);
            w_num[0] = w_r21 - w_r12;
            w_num[1] = w_r02 - w_r20;
            w_num[2] = w_r10 - w_r01;
        end else if ((w_r00 > w_r11) && (w_r00 > w_r22)) begin
            w_branch = mtd_pkg::BR_X;
            w_arg    = 35'(mtd_pkg::Q30_ONE) + w_r00 - w_r11 - w_r22;
            w_num[0] = w_r01 + w_r10;
            w_num[1] = w_r02 + w_r20;
            w_num[2] = w_r21 - w_r12;
        end else if (w_r11 > w_r22) begin
            w_branch = mtd_pkg::BR_Y;
            w_arg    = 35'(mtd_pkg::Q30_ONE) + w_r11 - w_r00 - w_r22;
            w_num[0] = w_r01 + w_r10;
            w_num[1] = w_r12 + w_r21;
            w_num[2] = w_r02 - w_r20;
        end else begin
            w_branch = mtd_pkg::BR_Z;
            w_arg    = 35'(mtd_pkg::Q30_ONE) + w_r22 - w_r00 - w_r11;
            w_num[0] = w_r02 + w_r20;
            w_num[1] = w_r12 + w_r21;
            w_num[2] = w_r10 - w_r01;
        end
    end

    // Clamp the argument at zero and move it to Q4.60 for the root
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_darg <= w_arg[34] ? 64'd0 : 64'({w_arg[32:0], 30'd0});
        end
    end

    // ------------------------------------------------------------------
    // s = 2 * sqrt(arg); quaternion components are num / s
    // ------------------------------------------------------------------
    logic [31:0]          w_root2;
    logic [33:0]          w_s;
    logic signed [31:0]   w_q2 [0:2];
    mtd_pkg::t_side       r_side [mtd_pkg::ST_SIDE0:mtd_pkg::ST_Q];
    mtd_pkg::t_side       n_side [mtd_pkg::ST_SIDE0:mtd_pkg::ST_Q];

    mtd_sqrt u_root2 (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_x    (r_darg),
        .o_root (w_root2)
    );

    assign w_s = {1'b0, w_root2, 1'b0};

    for (genvar k = 0; k < 3; k++) begin : g_quat
        mtd_div u_quat (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_num ($signed(r_side[mtd_pkg::ST_S].num[k])),
            .i_den (w_s),
            .o_q   (w_q2[k])
        );
    end

    // Sideband line: fill in each field at the stage where it is known
    always_comb begin
        n_side[mtd_pkg::ST_SIDE0].move = r_mat[mtd_pkg::ST_LEN].move;
        for (int c = 0; c < 3; c++) begin
            n_side[mtd_pkg::ST_SIDE0].scale[c] =
                w_len[c][31] ? mtd_pkg::SCALE_MAX : w_len[c][30:0];
        end
        n_side[mtd_pkg::ST_SIDE0].zero   = (w_len[0] == '0) || (w_len[1] == '0) ||
                                           (w_len[2] == '0);
        n_side[mtd_pkg::ST_SIDE0].branch = mtd_pkg::BR_W;
        n_side[mtd_pkg::ST_SIDE0].num    = '0;
        n_side[mtd_pkg::ST_SIDE0].qs     = '0;
        for (int k = mtd_pkg::ST_SIDE0 + 1; k <= mtd_pkg::ST_Q; k++) begin
            n_side[k] = r_side[k-1];
            if (k == mtd_pkg::ST_D) begin
                n_side[k].branch = w_branch;
                n_side[k].num    = w_num;
            end
            if (k == mtd_pkg::ST_QS) begin
                n_side[k].qs = {1'b0, w_root2[31:1]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = mtd_pkg::ST_SIDE0; k <= mtd_pkg::ST_Q; k++) begin
                r_side[k] <= n_side[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Assemble the result; identity when a column had zero length
    // ------------------------------------------------------------------
    mtd_pkg::t_side      w_last;
    logic signed [31:0]  w_qs;
    mtd_pkg::t_out       n_out;
    mtd_pkg::t_out       r_out;

    assign w_last = r_side[mtd_pkg::ST_Q];
    assign w_qs   = (w_last.qs > mtd_pkg::Q30_ONE) ? $signed(mtd_pkg::Q30_ONE)
                                                  : $signed(w_last.qs);

    always_comb begin
        n_out.out_move_x = w_last.move[0];
        n_out.out_move_y = w_last.move[1];
        n_out.out_move_z = w_last.move[2];
        n_out.scale_x    = w_last.scale[0];
        n_out.scale_y    = w_last.scale[1];
        n_out.scale_z    = w_last.scale[2];
        n_out.rotation_valid = !w_last.zero;
        case (w_last.branch)
            mtd_pkg::BR_W: begin
                n_out.quat_x = w_q2[0];
                n_out.quat_y = w_q2[1];
                n_out.quat_z = w_q2[2];
                n_out.quat_w = w_qs;
            end
            mtd_pkg::BR_X: begin
                n_out.quat_x = w_qs;
                n_out.quat_y = w_q2[0];
                n_out.quat_z = w_q2[1];
                n_out.quat_w = w_q2[2];
            end
            mtd_pkg::BR_Y: begin
                n_out.quat_x = w_q2[0];
                n_out.quat_y = w_qs;
                n_out.quat_z = w_q2[1];
                n_out.quat_w = w_q2[2];
            end
            default: begin
                n_out.quat_x = w_q2[0];
                n_out.quat_y = w_q2[1];
                n_out.quat_z = w_qs;
                n_out.quat_w = w_q2[2];
            end
        endcase
        if (w_last.zero) begin
            n_out.quat_x = '0;
            n_out.quat_y = '0;
            n_out.quat_z = '0;
            n_out.quat_w = $signed(mtd_pkg::Q30_ONE);
        end
    end

    // Output register: hold while the sink stalls
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid = r_vld[ST_OUT];
    assign o_out.data  = r_out;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_identity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.data.rotation_valid) |->
            (o_out.data.quat_x == 0 && o_out.data.quat_y == 0 &&
             o_out.data.quat_z == 0 && o_out.data.quat_w == $signed(mtd_pkg::Q30_ONE)))
        else $error("invalid rotation without identity quaternion");

    a_zero_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.data.scale_x == 0 || o_out.data.scale_y == 0 ||
                         o_out.data.scale_z == 0)) |-> !o_out.data.rotation_valid)
        else $error("zero scale flagged as valid rotation");

    a_w_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.data.quat_w <= $signed(mtd_pkg::Q30_ONE) &&
                         o_out.data.quat_w >= -$signed(mtd_pkg::Q30_ONE) &&
                         o_out.data.quat_x <= $signed(mtd_pkg::Q30_ONE) &&
                         o_out.data.quat_x >= -$signed(mtd_pkg::Q30_ONE)))
        else $error("quaternion component out of range");

    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> r_vld[0])
        else $error("accepted item lost at pipeline entry");

endmodule
